[src/fifo_page_replacement_macros.svh]
// Assertion macros for the page replacement block.
// Each macro expands to one concurrent assertion checked on the rising edge
// of clk, disabled while rst is high.
`ifndef FIFO_PAGE_REPLACEMENT_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FPR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/fpr_pkg.sv]
package fpr_pkg;

   // Default table sizes
   localparam int PAGES_DEF  = 64;
   localparam int FRAMES_DEF = 16;

   // Width of the saturating fault counter
   localparam int FAULT_W = 32;

   // Read and write control of one table memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

[src/fpr_ram.sv]
module fpr_ram
   import fpr_pkg::*;
#(
   parameter int DEPTH = PAGES_DEF,
   parameter int AW    = 6,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  ram_ctl_type      ctl,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the last word when no read is issued
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fifo_page_replacement.sv]
// A hit delivers its item straight from the page table lookup; a miss also
// passes through S_WRITE and, once eviction checks run, first reads the frame
// table (S_FRAME) and the page table again (S_CHECK); table reads are registered.
// Only one item is in flight, paced by the serial read-modify-write sequence
// on the page table memory; rsp_stall can hold a result and the next item.
// Reset is synchronous; afterwards the page table is swept invalid entry by
// entry, during which req_stall stays high.
module fifo_page_replacement
   import fpr_pkg::*;
#(
   parameter int PAGES  = PAGES_DEF,
   parameter int FRAMES = FRAMES_DEF,
   localparam int PW    = $clog2(PAGES),
   localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int CW    = $clog2(FRAMES + 1)
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CW-1:0]      csr_frames_in_use,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PW-1:0]      req_page,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [FW-1:0]      rsp_frame,
   output logic               rsp_evicted_valid,
   output logic [PW-1:0]      rsp_evicted_page,
   output logic [FAULT_W-1:0] rsp_fault_total
);

`include "fifo_page_replacement_macros.svh"

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_LOOK  = 6'b000100,
      S_FRAME = 6'b001000,
      S_CHECK = 6'b010000,
      S_WRITE = 6'b100000
   } state_type;

   localparam int PTW = FW + 1;

   state_type          state_ff, state_in;
   logic [PW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]      frames_ff;
   logic [FW-1:0]      next_frame_ff, next_frame_in;
   logic               all_filled_ff, all_filled_in;
   logic [FAULT_W-1:0] faults_ff, faults_in;
   logic [PW-1:0]      page_ff, page_in;
   logic [FW-1:0]      cur_ff, cur_in;
   logic [PW-1:0]      old_ff, old_in;
   logic               ev_ff, ev_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [FW-1:0]      rsp_frame_ff, rsp_frame_in;
   logic               rsp_ev_ff, rsp_ev_in;
   logic [PW-1:0]      rsp_evp_ff, rsp_evp_in;
   logic [FAULT_W-1:0] rsp_faults_ff, rsp_faults_in;

   ram_ctl_type        pt_ctl, ft_ctl;
   logic [PW-1:0]      pt_wr_addr, pt_rd_addr;
   logic [PTW-1:0]     pt_wr_data, pt_rd_data;
   logic [FW-1:0]      ft_wr_addr, ft_rd_addr;
   logic [PW-1:0]      ft_wr_data, ft_rd_data;

   logic [CW-1:0]      n_frames;
   logic [CW-1:0]      cur_inc;
   logic               can_load;
   logic [PW-1:0]      req_page_mod;
   logic [PW-1:0]      ft_page_mod;

   // Page table: valid bit over frame number
   fpr_ram #(.DEPTH(PAGES), .AW(PW), .WIDTH(PTW)) u_page_table (
      .clock   (clock),
      .ctl     (pt_ctl),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   // Frame table: page held in each frame
   fpr_ram #(.DEPTH(FRAMES), .AW(FW), .WIDTH(PW)) u_frame_table (
      .clock   (clock),
      .ctl     (ft_ctl),
      .wr_addr (ft_wr_addr),
      .wr_data (ft_wr_data),
      .rd_addr (ft_rd_addr),
      .rd_data (ft_rd_data)
   );

   // Clamp the frame count to 1..FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         n_frames = CW'(1);
      end else if (frames_ff > CW'(FRAMES)) begin
         n_frames = CW'(FRAMES);
      end else begin
         n_frames = frames_ff;
      end
   end

   // Fold page numbers into the table range
   assign req_page_mod = ({1'b0, req_page} >= (PW+1)'(PAGES)) ?
                         PW'(req_page - PW'(PAGES)) : req_page;
   assign ft_page_mod  = ({1'b0, ft_rd_data} >= (PW+1)'(PAGES)) ?
                         PW'(ft_rd_data - PW'(PAGES)) : ft_rd_data;

   assign cur_inc   = CW'(cur_ff) + CW'(1);
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);

   // Sequence one item through the tables
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      next_frame_in = next_frame_ff;
      all_filled_in = all_filled_ff;
      faults_in     = faults_ff;
      page_in       = page_ff;
      cur_in        = cur_ff;
      old_in        = old_ff;
      ev_in         = ev_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evp_in    = rsp_evp_ff;
      rsp_faults_in = rsp_faults_ff;

      pt_ctl        = '0;
      pt_wr_addr    = page_ff;
      pt_wr_data    = {1'b1, cur_ff};
      pt_rd_addr    = req_page_mod;
      ft_ctl        = '0;
      ft_wr_addr    = cur_ff;
      ft_wr_data    = page_ff;
      ft_rd_addr    = cur_ff;

      case (state_ff)
         S_CLEAR: begin
            // Sweep every page entry invalid
            pt_ctl.wr_en = 1'b1;
            pt_wr_addr   = clr_ff;
            pt_wr_data   = '0;
            clr_in       = PW'(clr_ff + PW'(1));
            if (clr_ff == PW'(PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Take an item and start the page lookup
            if (req_valid) begin
               pt_ctl.rd_en = 1'b1;
               page_in      = req_page_mod;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            ev_in = 1'b0;
            if (pt_rd_data[FW]) begin
               // Hit: report the resident frame
               if (can_load) begin
                  rsp_valid_in  = 1'b1;
                  rsp_hit_in    = 1'b1;
                  rsp_frame_in  = pt_rd_data[FW-1:0];
                  rsp_ev_in     = 1'b0;
                  rsp_evp_in    = '0;
                  rsp_faults_in = faults_ff;
                  state_in      = S_IDLE;
               end
            end else begin
               // Miss: pick the victim frame, wrapping a stale pointer
               if (CW'(next_frame_ff) >= n_frames) begin
                  cur_in        = '0;
                  all_filled_in = 1'b1;
               end else begin
                  cur_in = next_frame_ff;
               end
               if (all_filled_ff || (CW'(next_frame_ff) >= n_frames)) begin
                  ft_ctl.rd_en = 1'b1;
                  ft_rd_addr   = cur_in;
                  state_in     = S_FRAME;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_FRAME: begin
            // Look up the page the frame last held
            old_in       = ft_page_mod;
            pt_ctl.rd_en = 1'b1;
            pt_rd_addr   = ft_page_mod;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            // Evict that page only if it still maps to this frame
            if (pt_rd_data[FW] && (pt_rd_data[FW-1:0] == cur_ff)) begin
               pt_ctl.wr_en = 1'b1;
               pt_wr_addr   = old_ff;
               pt_wr_data   = '0;
               ev_in        = 1'b1;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // Load the page, advance the pointer and count the fault
            if (can_load) begin
               pt_ctl.wr_en = 1'b1;
               ft_ctl.wr_en = 1'b1;
               if (cur_inc >= n_frames) begin
                  next_frame_in = '0;
                  all_filled_in = 1'b1;
               end else begin
                  next_frame_in = FW'(cur_inc);
               end
               if (faults_ff != '1) begin
                  faults_in = faults_ff + FAULT_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_frame_in  = cur_ff;
               rsp_ev_in     = ev_ff;
               rsp_evp_in    = ev_ff ? old_ff : '0;
               rsp_faults_in = (faults_ff != '1) ? faults_ff + FAULT_W'(1) : faults_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         frames_ff     <= CW'(FRAMES);
         next_frame_ff <= '0;
         all_filled_ff <= 1'b0;
         faults_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         next_frame_ff <= next_frame_in;
         all_filled_ff <= all_filled_in;
         faults_ff     <= faults_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            frames_ff <= csr_frames_in_use;
         end
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      cur_ff        <= cur_in;
      old_ff        <= old_in;
      ev_ff         <= ev_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evp_ff    <= rsp_evp_in;
      rsp_faults_ff <= rsp_faults_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_evp_ff;
   assign rsp_fault_total   = rsp_faults_ff;

   `FPR_ASSERT_NOW(a_hit_no_evict, clock, reset,
      rsp_valid_ff && rsp_hit_ff, !rsp_ev_ff, "hit item reports an eviction")
   `FPR_ASSERT_NOW(a_evict_when_full, clock, reset,
      rsp_valid_ff && rsp_ev_ff, all_filled_ff, "eviction before all frames filled")
   `FPR_ASSERT_NEXT(a_fault_step, clock, reset,
      (state_ff == S_WRITE) && can_load && (faults_ff != '1),
      faults_ff == $past(faults_ff) + FAULT_W'(1), "fault counter did not advance on a miss")
   `FPR_ASSERT_NOW(a_clear_stalls, clock, reset,
      state_ff == S_CLEAR, req_stall && !rsp_valid_ff, "item activity during table clear")

endmodule
